// File: rtl/hbae_pkg.sv
`timescale 1ns / 1ps

package hbae_pkg;

  // Array sizes
  localparam int NUM_KINDS    = 3;
  localparam int NUM_CHANNELS = 4;
  localparam int QUEUE_DEPTH  = 8;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int KIND_W = 2;
  localparam int CHAN_W = 3;
  localparam int VAL_W  = 32;
  localparam int TIME_W = 48;
  localparam int RPT_W  = 11;
  localparam int MASK_W = 3;
  localparam int POP_KIND_W = 2;
  localparam int POP_CHAN_W = 2;

  // Derived index widths
  localparam int FLAT_N  = NUM_KINDS * NUM_CHANNELS;
  localparam int FIDX_W  = (FLAT_N > 1) ? $clog2(FLAT_N) : 1;
  localparam int KIDX_W  = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W  = QIDX_W + 1;

  // Arithmetic constants
  localparam int SAFETY_KIND   = 2;
  localparam int COOLDOWN_MS   = 30000;
  localparam int MS_PER_MINUTE = 60000;
  localparam int LOW_FACTOR    = 62259;
  localparam int RPTMS_W       = 27;
  localparam int PROD_W        = 48;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SAFETY = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_MINUTES  = 2'd0,
    REG_FLASH_ENABLE    = 2'd1,
    REG_VOICE_ENABLE    = 2'd2,
    REG_VOICE_TYPE_MASK = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic stage;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [POP_KIND_W-1:0] kind;
    logic [POP_CHAN_W-1:0] chan;
    logic [VAL_W-1:0]      value;
  } pend_entry_t;

  typedef struct packed {
    logic                  announce;
    logic                  breached_now;
    logic                  flash_queued;
    logic                  flash_dropped;
    logic                  pop_valid;
    logic [POP_KIND_W-1:0] pop_kind;
    logic [POP_CHAN_W-1:0] pop_channel;
    logic [VAL_W-1:0]      pop_value;
  } result_t;

endpackage

// File: rtl/hbae_if.sv
`timescale 1ns / 1ps

interface hbae_in_if;
  logic                           valid;
  logic                           ready;
  logic [hbae_pkg::CMD_W-1:0]     command;
  logic [hbae_pkg::KIND_W-1:0]    alert_kind;
  logic [hbae_pkg::CHAN_W-1:0]    channel;
  logic [hbae_pkg::VAL_W-1:0]     sample_value;
  logic [hbae_pkg::VAL_W-1:0]     limit;
  logic                           is_safe;
  logic [hbae_pkg::TIME_W-1:0]    time_ms;

  modport source (output valid, command, alert_kind, channel, sample_value, limit,
                  is_safe, time_ms, input ready);
  modport sink (input valid, command, alert_kind, channel, sample_value, limit,
                is_safe, time_ms, output ready);
endinterface

interface hbae_out_if;
  logic                            valid;
  logic                            ready;
  logic                            announce;
  logic                            breached_now;
  logic                            flash_queued;
  logic                            flash_dropped;
  logic                            pop_valid;
  logic [hbae_pkg::POP_KIND_W-1:0] pop_kind;
  logic [hbae_pkg::POP_CHAN_W-1:0] pop_channel;
  logic [hbae_pkg::VAL_W-1:0]      pop_value;

  modport source (output valid, announce, breached_now, flash_queued, flash_dropped,
                  pop_valid, pop_kind, pop_channel, pop_value, input ready);
  modport sink (input valid, announce, breached_now, flash_queued, flash_dropped,
                pop_valid, pop_kind, pop_channel, pop_value, output ready);
endinterface

// File: rtl/hbae_ctrl.sv
`timescale 1ns / 1ps

module hbae_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hbae_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EVAL
  } state_t;

  state_t state;
  logic   commit_ok;

  assign in_ready    = (state == ST_IDLE);
  // Commit only when the output register is free or is emptied this cycle
  assign commit_ok   = (state == ST_EVAL) && (!out_valid || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.stage   = (state == ST_LOAD);
  assign cmd.commit  = commit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (commit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (commit_ok) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/hbae_dp.sv
`timescale 1ns / 1ps

module hbae_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  hbae_pkg::ctrl_cmd_t                cmd,
  input  logic [hbae_pkg::CMD_W-1:0]         in_command,
  input  logic [hbae_pkg::KIND_W-1:0]        in_kind,
  input  logic [hbae_pkg::CHAN_W-1:0]        in_chan,
  input  logic [hbae_pkg::VAL_W-1:0]         in_value,
  input  logic [hbae_pkg::VAL_W-1:0]         in_limit,
  input  logic                               in_safe,
  input  logic [hbae_pkg::TIME_W-1:0]        in_time,
  input  logic                               cfg_we,
  input  logic [hbae_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbae_pkg::CFG_DATA_W-1:0]    cfg_data,
  output hbae_pkg::result_t                  result
);

  localparam int TIME_W = hbae_pkg::TIME_W;
  localparam int VAL_W  = hbae_pkg::VAL_W;

  // Configuration
  logic [hbae_pkg::RPT_W-1:0]   repeat_min;
  logic                         flash_en;
  logic                         voice_en;
  logic [hbae_pkg::MASK_W-1:0]  voice_mask;
  logic [hbae_pkg::RPTMS_W-1:0] rep_ms;

  // Per-channel and per-kind state
  logic [hbae_pkg::FLAT_N-1:0]  breach_flag;
  logic [TIME_W-1:0]            ann_time [hbae_pkg::FLAT_N];
  logic [VAL_W-1:0]             ann_value [hbae_pkg::FLAT_N];
  logic [TIME_W-1:0]            flash_time [hbae_pkg::NUM_KINDS];

  // Pending flash queue
  hbae_pkg::pend_entry_t        pend_mem [hbae_pkg::QUEUE_DEPTH];
  hbae_pkg::pend_entry_t        pend_rd;
  logic [hbae_pkg::QIDX_W-1:0]  head;
  logic [hbae_pkg::QCNT_W-1:0]  count;

  // Captured word
  hbae_pkg::cmd_code_t          cmd_q;
  logic [hbae_pkg::KIND_W-1:0]  kind_q;
  logic [hbae_pkg::FIDX_W-1:0]  idx_q;
  logic [hbae_pkg::KIDX_W-1:0]  kidx_q;
  logic [VAL_W-1:0]             val_q;
  logic [VAL_W-1:0]             lim_q;
  logic                         safe_q;
  logic [TIME_W-1:0]            t_q;
  logic                         rng_q;
  logic                         zero_q;

  // Staged reads
  logic [VAL_W-1:0]             low_q;
  logic                         flag_q;
  logic [VAL_W-1:0]             ann_val_q;
  logic [TIME_W-1:0]            el_ann_q;
  logic [TIME_W-1:0]            el_fl_q;

  // Capture decode
  logic [hbae_pkg::KIND_W-1:0]  kind_eff;
  logic                         cap_rng;
  logic                         cap_safety;
  logic [hbae_pkg::PROD_W-1:0]  low_prod;

  // Evaluation
  logic samp, safety, live, above, below, set_e, clr_e;
  logic enter, rep_due, speak, flag_new, flash_try, full, enq, drop, pop_ok;
  logic [hbae_pkg::MASK_W-1:0]  mask_sh;
  logic [hbae_pkg::QSUM_W-1:0]  tail_sum;
  logic [hbae_pkg::QIDX_W-1:0]  tail;
  logic [hbae_pkg::QIDX_W-1:0]  head_next;
  hbae_pkg::result_t            res_next;

  // Recover the channel of a flat index, masked to the stored width
  function automatic logic [hbae_pkg::POP_CHAN_W-1:0] idx_chan(
      input logic [hbae_pkg::FIDX_W-1:0] idx);
    return hbae_pkg::POP_CHAN_W'(int'(idx) % hbae_pkg::NUM_CHANNELS);
  endfunction

  assign cap_safety = (hbae_pkg::cmd_code_t'(in_command) == hbae_pkg::CMD_SAFETY);
  assign kind_eff   = cap_safety ? hbae_pkg::KIND_W'(hbae_pkg::SAFETY_KIND) : in_kind;
  assign cap_rng    = (int'(kind_eff) < hbae_pkg::NUM_KINDS) &&
                      (int'(in_chan) < hbae_pkg::NUM_CHANNELS);

  assign low_prod = hbae_pkg::PROD_W'(lim_q) * hbae_pkg::PROD_W'(hbae_pkg::LOW_FACTOR);

  // Capture the word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= hbae_pkg::cmd_code_t'(in_command);
      kind_q <= kind_eff;
      idx_q  <= cap_rng ? hbae_pkg::FIDX_W'(int'(kind_eff) * hbae_pkg::NUM_CHANNELS +
                                            int'(in_chan)) : '0;
      kidx_q <= cap_rng ? hbae_pkg::KIDX_W'(kind_eff) : '0;
      val_q  <= cap_safety ? '0 : in_value;
      lim_q  <= in_limit;
      safe_q <= in_safe;
      t_q    <= in_time;
      rng_q  <= cap_rng;
      zero_q <= (in_value == '0) || (in_limit == '0);
    end
  end

  // Stage: low threshold, state reads, elapsed times
  always_ff @(posedge clk) begin
    rep_ms <= hbae_pkg::RPTMS_W'(int'(repeat_min) * hbae_pkg::MS_PER_MINUTE);
    pend_rd <= pend_mem[head];
    if (cmd.stage) begin
      low_q     <= low_prod[hbae_pkg::PROD_W-1:16];
      flag_q    <= breach_flag[idx_q];
      ann_val_q <= ann_value[idx_q];
      el_ann_q  <= t_q - ann_time[idx_q];
      el_fl_q   <= t_q - flash_time[kidx_q];
    end
  end

  // Evaluate
  always_comb begin
    samp   = (cmd_q == hbae_pkg::CMD_SAMPLE);
    safety = (cmd_q == hbae_pkg::CMD_SAFETY);
    live   = rng_q && ((samp && !zero_q) || safety);
    above  = val_q > lim_q;
    below  = val_q < low_q;
    set_e  = samp ? above : !safe_q;
    clr_e  = samp ? (!above && below) : safe_q;
    enter  = set_e && !flag_q;
    rep_due = flag_q && (rep_ms != '0) && (el_ann_q >= TIME_W'(rep_ms)) &&
              (!samp || (val_q != ann_val_q));
    speak  = live && !clr_e && (enter || rep_due);
    flag_new = flag_q;
    if (live) begin
      if (clr_e) flag_new = 1'b0;
      else if (enter) flag_new = 1'b1;
    end
    flash_try = live && flag_new && flash_en &&
                (el_fl_q >= TIME_W'(hbae_pkg::COOLDOWN_MS));
    full   = (count == hbae_pkg::QCNT_W'(hbae_pkg::QUEUE_DEPTH));
    enq    = flash_try && !full;
    drop   = flash_try && full;
    pop_ok = (cmd_q == hbae_pkg::CMD_POP) && (count != '0);

    tail_sum = {1'b0, head} + hbae_pkg::QSUM_W'(count);
    if (tail_sum >= hbae_pkg::QSUM_W'(hbae_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - hbae_pkg::QSUM_W'(hbae_pkg::QUEUE_DEPTH);
    end
    tail = tail_sum[hbae_pkg::QIDX_W-1:0];
    head_next = (head == hbae_pkg::QIDX_W'(hbae_pkg::QUEUE_DEPTH - 1)) ?
                '0 : head + 1'b1;

    mask_sh = voice_mask >> kind_q;

    res_next               = '0;
    res_next.announce      = speak && voice_en && mask_sh[0];
    res_next.breached_now  = rng_q && (samp || safety) && flag_new;
    res_next.flash_queued  = enq;
    res_next.flash_dropped = drop;
    if (pop_ok) begin
      res_next.pop_valid   = 1'b1;
      res_next.pop_kind    = pend_rd.kind;
      res_next.pop_channel = pend_rd.chan;
      res_next.pop_value   = pend_rd.value;
    end
  end

  // Payload state: announcement history, queue storage, output word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= res_next;
      if (speak) begin
        ann_time[idx_q]  <= t_q;
        ann_value[idx_q] <= val_q;
      end
      if (enq) begin
        pend_mem[tail] <= '{kind: kind_q, chan: idx_chan(idx_q), value: val_q};
      end
    end
  end

  // Control state: config, flags, cooldowns, queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_min  <= '0;
      flash_en    <= 1'b1;
      voice_en    <= 1'b0;
      voice_mask  <= '1;
      breach_flag <= '0;
      for (int k = 0; k < hbae_pkg::NUM_KINDS; k++) begin
        flash_time[k] <= '0;
      end
      head  <= '0;
      count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (hbae_pkg::cfg_reg_t'(cfg_index))
          hbae_pkg::REG_REPEAT_MINUTES:  repeat_min <= cfg_data;
          hbae_pkg::REG_FLASH_ENABLE:    flash_en   <= cfg_data[0];
          hbae_pkg::REG_VOICE_ENABLE:    voice_en   <= cfg_data[0];
          hbae_pkg::REG_VOICE_TYPE_MASK: voice_mask <= cfg_data[hbae_pkg::MASK_W-1:0];
        endcase
      end
      if (cmd.commit) begin
        if (live) breach_flag[idx_q] <= flag_new;
        if (flash_try) flash_time[kidx_q] <= t_q;
        if (enq && !pop_ok) count <= count + 1'b1;
        if (pop_ok) begin
          head  <= head_next;
          count <= count - 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/hysteresis_breach_alert_engine_unit.sv
// Hysteresis breach alert engine: one result word per accepted command word.
// The three-step controller sequence: capture at the accepting edge, stage of the
// threshold multiply and state reads, then evaluate and commit.
// A new word is accepted only after the previous one has committed; the commit
// step holds while the output register still waits to be taken.
// Reset (rst, synchronous, active high) clears breach flags, flash cooldowns,
// the pending queue pointers and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps

module hysteresis_breach_alert_engine_unit (
  input  logic                            clk,
  input  logic                            rst,
  hbae_in_if.sink                         in_ch,
  hbae_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [hbae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbae_pkg::CFG_DATA_W-1:0] cfg_data
);

  hbae_pkg::ctrl_cmd_t cmd;
  hbae_pkg::result_t   result;
  logic                in_ready;
  logic                out_valid;

  // Controller: sequences capture, stage and commit, and owns the output valid.
  // A new word is taken while a finished result still waits in the output register;
  // the commit step holds until that register is free.
  hbae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: breach flags, announcement history, per-kind cooldowns,
  // the pending flash queue and the registered result word.
  hbae_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_command (in_ch.command),
    .in_kind    (in_ch.alert_kind),
    .in_chan    (in_ch.channel),
    .in_value   (in_ch.sample_value),
    .in_limit   (in_ch.limit),
    .in_safe    (in_ch.is_safe),
    .in_time    (in_ch.time_ms),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .result     (result)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.announce      = result.announce;
  assign out_ch.breached_now  = result.breached_now;
  assign out_ch.flash_queued  = result.flash_queued;
  assign out_ch.flash_dropped = result.flash_dropped;
  assign out_ch.pop_valid     = result.pop_valid;
  assign out_ch.pop_kind      = result.pop_kind;
  assign out_ch.pop_channel   = result.pop_channel;
  assign out_ch.pop_value     = result.pop_value;

endmodule

// File: test/hysteresis_breach_alert_engine_unit_tb.sv
`timescale 1ns / 1ps

module hysteresis_breach_alert_engine_unit_tb;
  import hbae_pkg::*;

  localparam int RESULT_LAG      = 2;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 220;

  // Direction a sample or safety state pushes the breach flag.
  typedef enum int {TR_HOLD, TR_CLEAR, TR_BREACH} trend_t;

  typedef struct {
    cmd_code_t         cmd;
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan;
    logic [VAL_W-1:0]  val;
    logic [VAL_W-1:0]  lim;
    logic              safe;
    logic [TIME_W-1:0] t;
  } cmd_word_t;

  // One row of the directed table. When typed is set, want holds a result
  // read straight off the spec, and it replaces the predicted one.
  typedef struct {
    cmd_word_t w;
    bit        typed;
    result_t   want;
  } stim_row_t;

  localparam result_t R_ZERO = '0;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hbae_in_if  in_ch ();
  hbae_out_if out_ch ();

  hysteresis_breach_alert_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Alert state as the block should hold it, all zero out of reset.
  bit                breached        [NUM_KINDS][NUM_CHANNELS];
  bit [TIME_W-1:0]   last_spoken_ms  [NUM_KINDS][NUM_CHANNELS];
  bit [VAL_W-1:0]    last_spoken_val [NUM_KINDS][NUM_CHANNELS];
  bit [TIME_W-1:0]   last_flash_ms   [NUM_KINDS];
  pend_entry_t       flash_fifo [$];

  // Register image, loaded with the reset defaults.
  bit [RPT_W-1:0]    rpt_min    = '0;
  bit                flash_on   = 1'b1;
  bit                voice_on   = 1'b0;
  bit [MASK_W-1:0]   voice_mask = 3'b111;

  result_t           due_results [$];
  int                mismatches = 0;

  // Traffic shaping knobs, changed per phase.
  int unsigned       idle_pct  = 0;
  int unsigned       stall_pct = 0;
  bit [TIME_W-1:0]   now_ms    = '0;
  bit [VAL_W-1:0]    slot_lim [NUM_KINDS][NUM_CHANNELS];
  stim_row_t         dir_tab [$];

  // Run the breach/announce/flash logic on one (kind, channel).
  function automatic result_t judge_alert(int unsigned kind, int unsigned chan,
                                          logic [VAL_W-1:0] val, trend_t trend,
                                          bit sampled, logic [TIME_W-1:0] t);
    result_t         r;
    logic [TIME_W-1:0] rpt_ms;
    logic [TIME_W-1:0] since;
    bit              speak;
    r      = '0;
    speak  = 1'b0;
    rpt_ms = TIME_W'(rpt_min) * TIME_W'(MS_PER_MINUTE);
    since  = t - last_spoken_ms[kind][chan];
    if (trend == TR_CLEAR) begin
      breached[kind][chan] = 1'b0;
    end else if (trend == TR_BREACH && !breached[kind][chan]) begin
      breached[kind][chan]        = 1'b1;
      last_spoken_ms[kind][chan]  = t;
      last_spoken_val[kind][chan] = val;
      speak = 1'b1;
    end else if (breached[kind][chan] && rpt_ms != 0 && since >= rpt_ms &&
                 (!sampled || val != last_spoken_val[kind][chan])) begin
      last_spoken_ms[kind][chan]  = t;
      last_spoken_val[kind][chan] = val;
      speak = 1'b1;
    end
    // Cooldown restarts on a pass even when the flash is then dropped.
    if (breached[kind][chan] && flash_on &&
        TIME_W'(t - last_flash_ms[kind]) >= TIME_W'(COOLDOWN_MS)) begin
      last_flash_ms[kind] = t;
      if (flash_fifo.size() < QUEUE_DEPTH) begin
        flash_fifo.push_back('{kind: kind[POP_KIND_W-1:0], chan: chan[POP_CHAN_W-1:0],
                               value: val});
        r.flash_queued = 1'b1;
      end else begin
        r.flash_dropped = 1'b1;
      end
    end
    r.announce     = speak && voice_on && voice_mask[kind];
    r.breached_now = breached[kind][chan];
    return r;
  endfunction

  // Expected result word for one accepted command word; updates the state.
  function automatic result_t predict_alert(cmd_word_t w);
    result_t       r;
    pend_entry_t   e;
    logic [VAL_W-1:0] low;
    trend_t        trend;
    r = '0;
    case (w.cmd)
      CMD_SAMPLE: begin
        if (w.kind < NUM_KINDS && w.chan < NUM_CHANNELS) begin
          if (w.val == 0 || w.lim == 0) begin
            r.breached_now = breached[w.kind][w.chan];
          end else begin
            low   = VAL_W'((64'(w.lim) * 64'(LOW_FACTOR)) >> 16);
            trend = (w.val > w.lim) ? TR_BREACH : (w.val < low) ? TR_CLEAR : TR_HOLD;
            r = judge_alert(w.kind, w.chan, w.val, trend, 1'b1, w.t);
          end
        end
      end
      CMD_SAFETY: begin
        if (SAFETY_KIND < NUM_KINDS && w.chan < NUM_CHANNELS)
          r = judge_alert(SAFETY_KIND, w.chan, '0, w.safe ? TR_CLEAR : TR_BREACH,
                          1'b0, w.t);
      end
      CMD_POP: begin
        if (flash_fifo.size() != 0) begin
          e             = flash_fifo.pop_front();
          r.pop_valid   = 1'b1;
          r.pop_kind    = e.kind;
          r.pop_channel = e.chan;
          r.pop_value   = e.value;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_word_t mk_word(cmd_code_t cmd, int unsigned kind, int unsigned chan,
                                        logic [VAL_W-1:0] val, logic [VAL_W-1:0] lim,
                                        bit safe, logic [TIME_W-1:0] t);
    cmd_word_t w;
    w.cmd  = cmd;
    w.kind = kind[KIND_W-1:0];
    w.chan = chan[CHAN_W-1:0];
    w.val  = val;
    w.lim  = lim;
    w.safe = safe;
    w.t    = t;
    return w;
  endfunction

  function automatic void add_row(cmd_word_t w, bit typed, result_t want);
    stim_row_t s;
    s.w     = w;
    s.typed = typed;
    s.want  = want;
    dir_tab.push_back(s);
  endfunction

  // Pick a threshold: spread over the full range, tiny ones, plain Q16.16
  // values and ones at the top of the range.
  function automatic logic [VAL_W-1:0] pick_limit();
    case ($urandom_range(3))
      0:       return $urandom() | 32'd1;
      1:       return $urandom_range(255, 1);
      2:       return $urandom_range(100 << 16, 1 << 16);
      default: return 32'hFFFF_FFFF - $urandom_range(1000);
    endcase
  endfunction

  // Advance the millisecond counter: mostly short steps, now and then whole
  // minutes, and rarely a jump anywhere, backward included.
  task automatic advance_ms();
    int unsigned p;
    p = $urandom_range(999);
    if (p < 20)
      now_ms = {16'($urandom()), 32'($urandom())};
    else if (p < 60)
      now_ms += TIME_W'(MS_PER_MINUTE) * TIME_W'($urandom_range(1500, 1));
    else if (p >= 150)
      now_ms += TIME_W'($urandom_range(20000, 1));
  endtask

  // Present one word, hold it until taken, then queue what it should produce.
  task automatic send_word(cmd_word_t w, bit typed, result_t want);
    result_t guess;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.command      <= w.cmd;
    in_ch.alert_kind   <= w.kind;
    in_ch.channel      <= w.chan;
    in_ch.sample_value <= w.val;
    in_ch.limit        <= w.lim;
    in_ch.is_safe      <= w.safe;
    in_ch.time_ms      <= w.t;
    do @(posedge clk); while (!in_ch.ready);
    guess = predict_alert(w);
    due_results.push_back(typed ? want : guess);
  endtask

  // Drop valid and let every expected word drain, plus some slack.
  task automatic settle(int unsigned extra);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_REPEAT_MINUTES:  rpt_min    = data[RPT_W-1:0];
      REG_FLASH_ENABLE:    flash_on   = data[0];
      REG_VOICE_ENABLE:    voice_on   = data[0];
      REG_VOICE_TYPE_MASK: voice_mask = data[MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic. Most samples hit a known limit per slot so the flag
  // walks through entry, hold band and exit; the rest is pops, safety
  // states and noise over the whole field ranges.
  task automatic run_mix(int unsigned n, int unsigned pop_pct);
    cmd_word_t        w;
    int unsigned      roll, kind, chan, mode;
    logic [VAL_W-1:0] lim, low, val;
    logic [VAL_W:0]   up;
    for (int unsigned i = 0; i < n; i++) begin
      advance_ms();
      roll = $urandom_range(99);
      if (roll < pop_pct) begin
        w = mk_word(CMD_POP, $urandom_range(3), $urandom_range(7), $urandom(), $urandom(),
                    $urandom_range(1), now_ms);
      end else if (roll < pop_pct + 14) begin
        chan = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(NUM_CHANNELS - 1);
        w = mk_word(CMD_SAFETY, $urandom_range(3), chan, $urandom(), $urandom(),
                    $urandom_range(2) == 0, now_ms);
      end else if (roll < 92) begin
        kind = $urandom_range(NUM_KINDS - 1);
        chan = $urandom_range(NUM_CHANNELS - 1);
        if ($urandom_range(29) == 0)
          slot_lim[kind][chan] = pick_limit();
        lim  = slot_lim[kind][chan];
        low  = VAL_W'((64'(lim) * 64'(LOW_FACTOR)) >> 16);
        mode = $urandom_range(9);
        if (mode < 4) begin
          up  = {1'b0, lim} + (VAL_W + 1)'($urandom_range(5000, 1));
          val = up[VAL_W] ? 32'hFFFF_FFFF : up[VAL_W-1:0];
        end else if (mode < 6) begin
          val = low + $urandom_range(lim - low);
        end else if (mode < 9) begin
          val = (low > 1) ? $urandom_range(low - 1, 1) : 32'd1;
        end else begin
          val = $urandom_range(1) ? lim : low;
        end
        w = mk_word(CMD_SAMPLE, kind, chan, val, lim, $urandom_range(1), now_ms);
      end else begin
        w = mk_word(cmd_code_t'($urandom_range(3)), $urandom_range(3), $urandom_range(7),
                    ($urandom_range(3) == 0) ? 32'd0 : $urandom(),
                    ($urandom_range(3) == 0) ? 32'd0 : $urandom(),
                    $urandom_range(1), now_ms);
      end
      send_word(w, 1'b0, R_ZERO);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Sink side: stall at the phase's rate.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result word taken from the block with the oldest expectation.
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("announce",      want.announce,      out_ch.announce);
        check_field("breached_now",  want.breached_now,  out_ch.breached_now);
        check_field("flash_queued",  want.flash_queued,  out_ch.flash_queued);
        check_field("flash_dropped", want.flash_dropped, out_ch.flash_dropped);
        check_field("pop_valid",     want.pop_valid,     out_ch.pop_valid);
        check_field("pop_kind",      want.pop_kind,      out_ch.pop_kind);
        check_field("pop_channel",   want.pop_channel,   out_ch.pop_channel);
        check_field("pop_value",     want.pop_value,     out_ch.pop_value);
      end
    end
  end

  initial begin : stimulus
    result_t     r_hit;
    int unsigned rpt, fl, vo, mask;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_NOP;
    in_ch.alert_kind   = '0;
    in_ch.channel      = '0;
    in_ch.sample_value = '0;
    in_ch.limit        = '0;
    in_ch.is_safe      = 1'b0;
    in_ch.time_ms      = '0;
    for (int k = 0; k < NUM_KINDS; k++)
      for (int c = 0; c < NUM_CHANNELS; c++)
        slot_lim[k][c] = pick_limit();

    // Flag set, nothing else: voice is off at reset and the first flash of a
    // kind is held back until the counter passes the cooldown.
    r_hit              = '0;
    r_hit.breached_now = 1'b1;

    // Directed table, run on the reset register values.
    add_row(mk_word(CMD_POP,    0, 0, '0, '0, 0, '0), 1, R_ZERO);           // empty queue
    add_row(mk_word(CMD_NOP,    3, 7, '1, '1, 1, '1), 1, R_ZERO);           // no operation
    add_row(mk_word(CMD_SAMPLE, 3, 0, 32'h2_0000, 32'h1_0000, 0, 500), 1, R_ZERO); // bad kind
    add_row(mk_word(CMD_SAMPLE, 0, 7, 32'h2_0000, 32'h1_0000, 0, 550), 1, R_ZERO); // bad chan
    add_row(mk_word(CMD_SAFETY, 2, 4, '0, '0, 0, 600), 1, R_ZERO);          // bad chan, safety
    add_row(mk_word(CMD_SAMPLE, 0, 0, '0, 32'h1_0000, 0, 700), 1, R_ZERO);  // zero value
    add_row(mk_word(CMD_SAMPLE, 0, 0, 32'h2_0000, '0, 0, 800), 1, R_ZERO);  // zero limit
    add_row(mk_word(CMD_SAMPLE, 0, 0, 32'h2_0000, 32'h1_0000, 0, 1000), 1, r_hit); // entry
    add_row(mk_word(CMD_SAMPLE, 0, 0, '0, 32'd1, 0, 1500), 1, r_hit);       // ignored, flag kept
    // Hold band, first flash once the cooldown from zero has run out.
    add_row(mk_word(CMD_SAMPLE, 0, 0, 32'hF400, 32'h1_0000, 0, 40000), 0, R_ZERO);
    add_row(mk_word(CMD_SAMPLE, 0, 0, 32'hF333, 32'h1_0000, 1, 41000), 0, R_ZERO); // at low
    add_row(mk_word(CMD_SAMPLE, 0, 0, 32'hF332, 32'h1_0000, 0, 42000), 0, R_ZERO); // exit
    add_row(mk_word(CMD_SAMPLE, 1, 3, '1, 32'hFFFF_FFFE, 1, '1), 0, R_ZERO);       // extremes
    add_row(mk_word(CMD_SAMPLE, 1, 3, '1, '1, 0, 5), 0, R_ZERO);           // counter wrapped
    add_row(mk_word(CMD_SAFETY, 0, 3, '0, '0, 0, 90000), 0, R_ZERO);        // unsafe
    add_row(mk_word(CMD_SAFETY, 3, 3, '0, '0, 0, 130000), 0, R_ZERO);       // still unsafe
    add_row(mk_word(CMD_SAFETY, 1, 3, '1, '1, 1, 131000), 0, R_ZERO);       // safe clears
    add_row(mk_word(CMD_SAMPLE, 2, 1, 32'h8000_0000, 32'd1, 0, 200000), 0, R_ZERO);
    add_row(mk_word(CMD_SAMPLE, 2, 1, 32'h7FFF_FFFF, '1, 1, 48'h8000_0000_0000), 0, R_ZERO);
    for (int i = 0; i < 5; i++)
      add_row(mk_word(CMD_POP, 3, 7, '1, '1, 1, '1), 0, R_ZERO);            // drain the queue

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table with no idling on either side.
    foreach (dir_tab[i])
      send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
    now_ms = 48'd300000;

    // Random phases: each one writes a register setting while the block is
    // idle, then runs a traffic mix under one of the idling patterns.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle(RESULT_LAG + 3);
      case (ph)
        0:       begin rpt = 0;    fl = 1; vo = 0; mask = 7; end
        1:       begin rpt = 1;    fl = 1; vo = 1; mask = 7; end
        2:       begin rpt = 1440; fl = 1; vo = 1; mask = 0; end
        3:       begin rpt = 2;    fl = 0; vo = 1; mask = 5; end
        5:       begin rpt = 1;    fl = 1; vo = 1; mask = 3; end
        7:       begin rpt = 1440; fl = 1; vo = 1; mask = 7; end
        default: begin
          rpt  = $urandom_range(1440);
          fl   = $urandom_range(1);
          vo   = $urandom_range(1);
          mask = $urandom_range(7);
        end
      endcase
      write_reg(REG_REPEAT_MINUTES,  CFG_DATA_W'(rpt));
      write_reg(REG_FLASH_ENABLE,    CFG_DATA_W'(fl));
      write_reg(REG_VOICE_ENABLE,    CFG_DATA_W'(vo));
      write_reg(REG_VOICE_TYPE_MASK, CFG_DATA_W'(mask));
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 80; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      // Alternate heavy and light popping so the queue both fills and drains.
      run_mix(WORDS_PER_PHASE, (ph % 2 == 0) ? 25 : 6);
    end

    settle(RESULT_LAG * 8);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
